/* hdl/sda_pkg.sv */
// sda_pkg: shared types and constants for the supply to demand allocator
// holds transaction structs, cell control struct and error codes; no dependencies
package sda_pkg;

  localparam int PORT_LIMIT = 16;
  localparam int MAX_PASSES = 1000;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_EXCESS    = 2'd1;
  localparam logic [1:0] ERR_PASSES    = 2'd2;
  localparam logic [1:0] ERR_TOO_MANY  = 2'd3;

  localparam logic CFG_STRATEGY  = 1'b0;
  localparam logic CFG_TOLERANCE = 1'b1;

  typedef struct packed {
    logic [31:0] request;
    logic [31:0] supply;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  port_index;
    logic [31:0] granted;
    logic [1:0]  error_code;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

/* hdl/sda_cell.sv */
// sda_cell: one demand slot of the rotating chain, holds request and grant
// depends on sda_pkg for the cell control struct
module sda_cell import sda_pkg::*; (
  input  logic        clk,
  input  cell_ctl_t   ctl,
  input  logic [31:0] load_req,
  input  logic [31:0] nxt_req,
  input  logic [31:0] nxt_grant,
  output logic [31:0] req,
  output logic [31:0] grant
);

  // load a new demand, clear grants at batch start, or take the neighbor's slot
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req   <= load_req;
      grant <= '0;
    end else if (ctl.clear) begin
      grant <= '0;
    end else if (ctl.shift) begin
      req   <= nxt_req;
      grant <= nxt_grant;
    end
  end

endmodule

/* hdl/sda_div.sv */
// sda_div: restoring divider, one quotient bit per cycle, 32 by 5 bits
// imports sda_pkg; no other dependencies
module sda_div import sda_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [4:0]  divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [4:0]  count;
  logic [5:0]  part;
  logic [4:0]  dvs;
  logic [5:0]  trial;
  logic [5:0]  part_next;

  // shift in next dividend bit and try a subtract
  assign trial     = {part[4:0], quotient[31]};
  assign part_next = (trial >= {1'b0, dvs}) ? trial - {1'b0, dvs} : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= '0;
        part <= '0;
        dvs <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        part <= part_next;
        quotient <= {quotient[30:0], trial >= {1'b0, dvs}};
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/supply_to_demand_allocator.sv */
// supply_to_demand_allocator: top level, controller around a chain of 16 demand cells
// depends on sda_pkg, sda_cell and sda_div
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | in_item_t (request, supply, is_last)
//  out     | output    | out_valid/out_ready| out_item_t (port_index, granted, ...)
//  cfg     | input     | cfg_write          | cfg_index, cfg_data
//
// a demand transaction loads when accepted; the last one starts the allocation
// greedy mode rotates the chain once, one cell at the head per cycle
// even mode: each pass runs the divider, then rotates the chain once, up to 1000 passes
// results leave from the head cell as the chain rotates once, holding on output stalls
// reset is synchronous; inputs are refused from the last demand until the batch is out
module supply_to_demand_allocator import sda_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_write,
  input  logic      cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_GREEDY = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_LOOP   = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_PASS   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]  state;
  logic        strategy;
  logic [15:0] tolerance;
  logic [4:0]  port_count;
  logic        overflow;
  logic [35:0] total_request;
  logic [31:0] remaining;
  logic [4:0]  n;
  logic [4:0]  live_count;
  logic [9:0]  pass_count;
  logic [3:0]  idx;
  logic [1:0]  err;
  logic [31:0] share;

  logic [31:0] req   [PORT_LIMIT];
  logic [31:0] grant [PORT_LIMIT];
  cell_ctl_t   ctl   [PORT_LIMIT];
  logic [31:0] head_grant;

  logic        accept;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_q;
  logic        head_live;
  logic        rotate;
  logic [32:0] sum;
  logic [31:0] greedy_g;

  assign in_ready  = (state == S_LOAD);
  assign accept    = in_valid && in_ready;
  assign head_live = ({1'b0, idx} < n);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strategy  <= 1'b0;
      tolerance <= 16'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_STRATEGY:  strategy  <= cfg_data[0];
        CFG_TOLERANCE: tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // head cell arithmetic for greedy and water-filling
  assign greedy_g = (req[0] >= remaining) ? remaining : req[0];
  assign sum      = {1'b0, grant[0]} + {1'b0, share};

  always_comb begin
    head_grant = grant[0];
    if (head_live && state == S_GREEDY) begin
      head_grant = greedy_g;
    end else if (head_live && state == S_PASS) begin
      head_grant = (sum > {1'b0, req[0]}) ? req[0] : sum[31:0];
    end
  end

  assign rotate = (state == S_GREEDY) || (state == S_PASS) ||
                  (state == S_EMIT && (!head_live || out_ready));

  // chain of demand cells, cell k takes from cell k+1, the tail from the head
  for (genvar k = 0; k < PORT_LIMIT; k++) begin : g_cell
    always_comb begin
      ctl[k].load  = accept && !overflow && (port_count == 5'(k));
      ctl[k].clear = accept && in_data.is_last;
      ctl[k].shift = rotate;
    end
    if (k == PORT_LIMIT - 1) begin : g_tail
      sda_cell u_cell (
        .clk(clk), .ctl(ctl[k]), .load_req(in_data.request),
        .nxt_req(req[0]), .nxt_grant(head_grant),
        .req(req[k]), .grant(grant[k])
      );
    end else begin : g_body
      sda_cell u_cell (
        .clk(clk), .ctl(ctl[k]), .load_req(in_data.request),
        .nxt_req(req[k+1]), .nxt_grant(grant[k+1]),
        .req(req[k]), .grant(grant[k])
      );
    end
  end

  sda_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(remaining),
    .divisor(live_count), .done(div_done), .quotient(div_q)
  );

  assign div_start = (state == S_LOOP) && (live_count != '0) &&
                     ({4'd0, remaining} > {20'd0, tolerance}) &&
                     (pass_count < 10'(MAX_PASSES));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      port_count <= '0;
      overflow <= 1'b0;
      total_request <= '0;
      remaining <= '0;
      live_count <= '0;
      pass_count <= '0;
      idx <= '0;
      err <= ERR_OK;
      n <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (!overflow && port_count < 5'(PORT_LIMIT)) begin
              port_count <= port_count + 5'd1;
              total_request <= total_request + {4'd0, in_data.request};
            end else begin
              overflow <= 1'b1;
            end
            if (in_data.is_last) begin
              remaining <= in_data.supply;
              idx <= '0;
              pass_count <= '0;
              if (overflow || port_count >= 5'(PORT_LIMIT)) begin
                n <= 5'(PORT_LIMIT);
                err <= ERR_TOO_MANY;
                state <= S_EMIT;
              end else begin
                n <= port_count + 5'd1;
                live_count <= port_count + 5'd1;
                err <= ERR_OK;
                state <= strategy ? S_CHECK : S_GREEDY;
              end
            end
          end
        end
        S_GREEDY: begin
          if (head_live) remaining <= remaining - greedy_g;
          idx <= idx + 4'd1;
          if (idx == 4'd15) begin
            state <= S_EMIT;
            if ({4'd0, (head_live ? remaining - greedy_g : remaining)} >
                {20'd0, tolerance}) err <= ERR_EXCESS;
          end
        end
        S_CHECK: begin
          if ({4'd0, remaining} > total_request) begin
            err <= ERR_EXCESS;
            state <= S_EMIT;
          end else begin
            state <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (live_count == '0 || {4'd0, remaining} <= {20'd0, tolerance}) begin
            state <= S_EMIT;
          end else if (pass_count >= 10'(MAX_PASSES)) begin
            err <= ERR_PASSES;
            state <= S_EMIT;
          end else begin
            pass_count <= pass_count + 10'd1;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            share <= div_q;
            if (div_q == '0) begin
              state <= S_EMIT;
            end else begin
              live_count <= '0;
              idx <= '0;
              state <= S_PASS;
            end
          end
        end
        S_PASS: begin
          if (head_live) begin
            if (sum > {1'b0, req[0]}) begin
              remaining <= remaining - (req[0] - grant[0]);
            end else begin
              remaining <= remaining - share;
              if (sum < {1'b0, req[0]}) live_count <= live_count + 5'd1;
            end
          end
          idx <= idx + 4'd1;
          if (idx == 4'd15) state <= S_LOOP;
        end
        S_EMIT: begin
          if (rotate) begin
            idx <= idx + 4'd1;
            if (idx == 4'd15) begin
              state <= S_LOAD;
              port_count <= '0;
              overflow <= 1'b0;
              total_request <= '0;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // result from the head cell
  assign out_valid = (state == S_EMIT) && head_live;
  always_comb begin
    out_data.port_index  = idx;
    out_data.granted     = (err != ERR_OK) ? '0 : grant[0];
    out_data.error_code  = err;
    out_data.last_result = ({1'b0, idx} == n - 5'd1);
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("result shown while loading");
  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    pass_count <= 10'(MAX_PASSES)) else $error("pass count beyond limit");
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOP) |-> (live_count <= n)) else $error("live count above port count");
  a_last_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && rotate && idx == 4'd15) |=> (state == S_LOAD))
    else $error("batch did not close after final rotation");

endmodule
